/* rtl/core/ffra_pkg.sv */
`default_nettype none

package ffra_pkg;

   // sizing of the bookkeeping stores
   localparam int TABLE_ENTRIES = 16;
   localparam int FREE_ENTRIES  = 32;
   localparam int ADDR_BITS     = 20;
   localparam int LEN_W         = ADDR_BITS + 1;

   // index and count widths
   localparam int TI_W = $clog2(TABLE_ENTRIES);
   localparam int TC_W = $clog2(TABLE_ENTRIES + 1);
   localparam int HI_W = $clog2(FREE_ENTRIES);
   localparam int HC_W = $clog2(FREE_ENTRIES + 1);

   // fixed field widths of the channels
   localparam int MODE_W   = 2;
   localparam int BYTES_W  = 21;
   localparam int TYPE_W   = 4;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 3;
   localparam int REFS_W   = 16;
   localparam int ADDR_W   = 20;

   // largest pool and pool size after reset
   localparam logic [LEN_W-1:0] POOL_MAX   = {1'b1, {ADDR_BITS{1'b0}}};
   localparam logic [LEN_W-1:0] POOL_RESET =
      (ADDR_BITS < 20) ? POOL_MAX : LEN_W'(64'd1048576);

   // request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_RETAIN  = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_COMPACT = 2'd3
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_TOO_SMALL = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // element type codes
   localparam logic [TYPE_W-1:0] TY_INT      = 4'd0;
   localparam logic [TYPE_W-1:0] TY_FLOAT    = 4'd1;
   localparam logic [TYPE_W-1:0] TY_DOUBLE   = 4'd2;
   localparam logic [TYPE_W-1:0] TY_CHAR     = 4'd3;
   localparam logic [TYPE_W-1:0] TY_BOOL     = 4'd4;
   localparam logic [TYPE_W-1:0] TY_SHORT    = 4'd5;
   localparam logic [TYPE_W-1:0] TY_LONG     = 4'd6;
   localparam logic [TYPE_W-1:0] TY_LONGLONG = 4'd7;
   localparam logic [TYPE_W-1:0] TY_UNSIGNED = 4'd8;
   localparam logic [TYPE_W-1:0] TY_STRING   = 4'd9;
   localparam logic [TYPE_W-1:0] TY_OTHER    = 4'd15;

   // smallest legal request for an element type
   function automatic logic [3:0] min_for_type(input logic [TYPE_W-1:0] code);
      logic [3:0] m;
      case (code)
         TY_DOUBLE, TY_LONG, TY_LONGLONG: m = 4'd8;
         TY_INT, TY_FLOAT, TY_UNSIGNED:   m = 4'd4;
         TY_SHORT:                        m = 4'd2;
         default:                         m = 4'd1;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ffra_chan_if.sv */
`default_nettype none

// request channel
interface ffra_req_if;
   logic                             valid;
   logic                             ready;
   logic [ffra_pkg::MODE_W-1:0]      mode;
   logic [ffra_pkg::BYTES_W-1:0]     request_bytes;
   logic [ffra_pkg::TYPE_W-1:0]      type_code;
   logic [ffra_pkg::ID_W-1:0]        block_id;
   modport source (output valid, mode, request_bytes, type_code, block_id, input ready);
   modport sink   (input valid, mode, request_bytes, type_code, block_id, output ready);
endinterface

// result channel
interface ffra_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ffra_pkg::STATUS_W-1:0]    status;
   logic [ffra_pkg::ID_W-1:0]        result_id;
   logic [ffra_pkg::REFS_W-1:0]      ref_count;
   logic [ffra_pkg::ADDR_W-1:0]      block_address;
   logic [ffra_pkg::BYTES_W-1:0]     block_bytes;
   modport source (output valid, status, result_id, ref_count, block_address, block_bytes,
                   input ready);
   modport sink   (input valid, status, result_id, ref_count, block_address, block_bytes,
                   output ready);
endinterface

// pool size write channel
interface ffra_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ffra_pkg::BYTES_W-1:0]     pool_bytes;
   modport source (output valid, pool_bytes, input ready);
   modport sink   (input valid, pool_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/first_fit_refcount_allocator.sv */
// First-fit pool allocator with reference counts (bookkeeping only).
// req_ch carries one request: allocate, retain, release or compact. rsp_ch
// returns exactly one result per request. csr_ch writes the pool size and
// re-initializes the allocator: empty block table, one free region over the
// whole pool, ids restart at 1. Writes are taken only while idle.
// One request is worked at a time; req_ch.ready is low from acceptance
// until the result transfer. A sequencer walks the 16-entry block table and
// the 32-entry free list one entry per cycle through a single compare/add
// unit:
//   retain / release : a table walk to the slot, plus a free-list walk
//                      when a block is freed, plus a compaction when the
//                      freed region finds no room
//   allocate         : a first-fit scan over the free regions
//   compact          : a table walk per live block, then one free tail
// An allocate that misses compacts and scans again. The result sits in an
// output register and is held while rsp_ch.ready is low; no new request is
// taken until it transfers. Reset gives a 1 MiB pool, an empty table and
// next id 1.
`default_nettype none

module first_fit_refcount_allocator (
   input  logic       clock,
   input  logic       reset,
   ffra_req_if.sink   req_ch,
   ffra_rsp_if.source rsp_ch,
   ffra_csr_if.sink   csr_ch
);

   localparam int TE    = ffra_pkg::TABLE_ENTRIES;
   localparam int FE    = ffra_pkg::FREE_ENTRIES;
   localparam int AB    = ffra_pkg::ADDR_BITS;
   localparam int LW    = ffra_pkg::LEN_W;
   localparam int TI_W  = ffra_pkg::TI_W;
   localparam int TC_W  = ffra_pkg::TC_W;
   localparam int HI_W  = ffra_pkg::HI_W;
   localparam int HC_W  = ffra_pkg::HC_W;
   localparam int ID_W  = ffra_pkg::ID_W;
   localparam int RF_W  = ffra_pkg::REFS_W;
   localparam int BY_W  = ffra_pkg::BYTES_W;
   localparam int AD_W  = ffra_pkg::ADDR_W;

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_FIT        = 7'b0000010,
      S_LOOKUP     = 7'b0000100,
      S_FREE_SCAN  = 7'b0001000,
      S_FREE_MERGE = 7'b0010000,
      S_CMP        = 7'b0100000,
      S_DONE       = 7'b1000000
   } state_type;

   // sequencer and request registers
   state_type               state_ff, state_in;
   ffra_pkg::mode_type      mode_ff, mode_in;
   logic [BY_W-1:0]         req_bytes_ff, req_bytes_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [TI_W-1:0]         slot_ff, slot_in;
   logic [TC_W-1:0]         tbl_ix_ff, tbl_ix_in;
   logic [HC_W-1:0]         hole_ix_ff, hole_ix_in;
   logic                    second_ff, second_in;

   // compaction walk
   logic [TE-1:0]           moved_ff, moved_in;
   logic [TI_W-1:0]         pick_ff, pick_in;
   logic                    pick_ok_ff, pick_ok_in;
   logic [AB-1:0]           pick_base_ff, pick_base_in;
   logic [LW-1:0]           pick_len_ff, pick_len_in;
   logic [LW-1:0]           cursor_ff, cursor_in;

   // freed region and its left neighbor
   logic [AB-1:0]           fb_ff, fb_in;
   logic [LW-1:0]           fl_ff, fl_in;
   logic                    prev_ok_ff, prev_ok_in;
   logic [LW-1:0]           prev_end_ff, prev_end_in;
   logic [LW-1:0]           prev_len_ff, prev_len_in;

   // allocator state
   logic [LW-1:0]           pool_ff, pool_in;
   logic [TE-1:0]           entry_valid_ff, entry_valid_in;
   logic [ID_W-1:0]         entry_ident_ff [TE];
   logic [ID_W-1:0]         entry_ident_in [TE];
   logic [AB-1:0]           entry_base_ff [TE];
   logic [AB-1:0]           entry_base_in [TE];
   logic [LW-1:0]           entry_length_ff [TE];
   logic [LW-1:0]           entry_length_in [TE];
   logic [RF_W-1:0]         entry_refs_ff [TE];
   logic [RF_W-1:0]         entry_refs_in [TE];
   logic [AB-1:0]           hole_base_ff [FE];
   logic [AB-1:0]           hole_base_in [FE];
   logic [LW-1:0]           hole_length_ff [FE];
   logic [LW-1:0]           hole_length_in [FE];
   logic [HC_W-1:0]         hole_count_ff, hole_count_in;
   logic [ID_W-1:0]         next_ident_ff, next_ident_in;

   // result register
   ffra_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [RF_W-1:0]         rsp_refs_ff, rsp_refs_in;
   logic [AD_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [BY_W-1:0]         rsp_bytes_ff, rsp_bytes_in;

   // shared read ports and compare unit
   logic [TI_W-1:0]         t;
   logic [HI_W-1:0]         hk;
   logic [HI_W-1:0]         hk_left;
   logic [AB-1:0]           cur_hb;
   logic [LW-1:0]           cur_hl;
   logic                    hole_live;
   logic                    tbl_live;
   logic                    id_match;
   logic                    merge_left;
   logic                    merge_right;
   logic                    free_ok;
   logic [TI_W-1:0]         free_slot;
   logic [RF_W-1:0]         new_refs;
   logic [LW-1:0]           cfg_pool;

   assign t         = tbl_ix_ff[TI_W-1:0];
   assign hk        = hole_ix_ff[HI_W-1:0];
   assign hk_left   = hk - HI_W'(1);
   assign cur_hb    = hole_base_ff[hk];
   assign cur_hl    = hole_length_ff[hk];
   assign hole_live = hole_ix_ff < hole_count_ff;
   assign tbl_live  = tbl_ix_ff < TC_W'(TE);
   assign id_match  = entry_valid_ff[t] && (entry_ident_ff[t] == id_ff);
   assign merge_left  = prev_ok_ff && (prev_end_ff == LW'(fb_ff));
   assign merge_right = hole_live && ((LW'(fb_ff) + fl_ff) == LW'(cur_hb));

   // lowest free table slot
   always_comb begin
      free_ok   = 1'b0;
      free_slot = '0;
      for (int i = TE - 1; i >= 0; i--) begin
         if (!entry_valid_ff[i]) begin
            free_ok   = 1'b1;
            free_slot = TI_W'(i);
         end
      end
   end

   // pool size clamp for a register write
   always_comb begin
      if (csr_ch.pool_bytes == '0) begin
         cfg_pool = LW'(1);
      end else if (64'(csr_ch.pool_bytes) > 64'(ffra_pkg::POOL_MAX)) begin
         cfg_pool = ffra_pkg::POOL_MAX;
      end else begin
         cfg_pool = LW'(csr_ch.pool_bytes);
      end
   end

   // handshakes
   assign csr_ch.ready  = (state_ff == S_IDLE);
   assign req_ch.ready  = (state_ff == S_IDLE) && !csr_ch.valid;
   assign rsp_ch.valid  = (state_ff == S_DONE);
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.result_id     = rsp_id_ff;
   assign rsp_ch.ref_count     = rsp_refs_ff;
   assign rsp_ch.block_address = rsp_addr_ff;
   assign rsp_ch.block_bytes   = rsp_bytes_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      req_bytes_in   = req_bytes_ff;
      id_in          = id_ff;
      slot_in        = slot_ff;
      tbl_ix_in      = tbl_ix_ff;
      hole_ix_in     = hole_ix_ff;
      second_in      = second_ff;
      moved_in       = moved_ff;
      pick_in        = pick_ff;
      pick_ok_in     = pick_ok_ff;
      pick_base_in   = pick_base_ff;
      pick_len_in    = pick_len_ff;
      cursor_in      = cursor_ff;
      fb_in          = fb_ff;
      fl_in          = fl_ff;
      prev_ok_in     = prev_ok_ff;
      prev_end_in    = prev_end_ff;
      prev_len_in    = prev_len_ff;
      pool_in        = pool_ff;
      entry_valid_in = entry_valid_ff;
      entry_ident_in = entry_ident_ff;
      entry_base_in  = entry_base_ff;
      entry_length_in = entry_length_ff;
      entry_refs_in  = entry_refs_ff;
      hole_base_in   = hole_base_ff;
      hole_length_in = hole_length_ff;
      hole_count_in  = hole_count_ff;
      next_ident_in  = next_ident_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_refs_in    = rsp_refs_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      new_refs       = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_ch.valid) begin
               // pool size write re-initializes everything
               pool_in           = cfg_pool;
               entry_valid_in    = '0;
               hole_base_in[0]   = '0;
               hole_length_in[0] = cfg_pool;
               hole_count_in     = HC_W'(1);
               next_ident_in     = ID_W'(1);
            end else if (req_ch.valid) begin
               mode_in      = ffra_pkg::mode_type'(req_ch.mode);
               req_bytes_in = req_ch.request_bytes;
               id_in        = req_ch.block_id;
               rsp_status_in = ffra_pkg::ST_OK;
               rsp_id_in     = '0;
               rsp_refs_in   = '0;
               rsp_addr_in   = '0;
               rsp_bytes_in  = '0;
               case (ffra_pkg::mode_type'(req_ch.mode))
                  ffra_pkg::MODE_ALLOC: begin
                     if (req_ch.request_bytes <
                         BY_W'(ffra_pkg::min_for_type(req_ch.type_code))) begin
                        rsp_status_in = ffra_pkg::ST_TOO_SMALL;
                        state_in      = S_DONE;
                     end else if (!free_ok) begin
                        rsp_status_in = ffra_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        slot_in    = free_slot;
                        hole_ix_in = '0;
                        second_in  = 1'b0;
                        state_in   = S_FIT;
                     end
                  end
                  ffra_pkg::MODE_RETAIN, ffra_pkg::MODE_RELEASE: begin
                     tbl_ix_in = '0;
                     state_in  = S_LOOKUP;
                  end
                  default: begin
                     moved_in   = '0;
                     cursor_in  = '0;
                     tbl_ix_in  = '0;
                     pick_ok_in = 1'b0;
                     state_in   = S_CMP;
                  end
               endcase
            end
         end

         S_FIT: begin
            // first fit over the free list, one region a cycle
            if (hole_live) begin
               if (64'(cur_hl) >= 64'(req_bytes_ff)) begin
                  if (64'(cur_hl) > 64'(req_bytes_ff)) begin
                     hole_base_in[hk]   = cur_hb + AB'(req_bytes_ff);
                     hole_length_in[hk] = cur_hl - LW'(req_bytes_ff);
                  end else begin
                     for (int j = 0; j < FE - 1; j++) begin
                        if (j >= int'(hk)) begin
                           hole_base_in[j]   = hole_base_ff[j+1];
                           hole_length_in[j] = hole_length_ff[j+1];
                        end
                     end
                     hole_count_in = hole_count_ff - HC_W'(1);
                  end
                  entry_valid_in[slot_ff]  = 1'b1;
                  entry_ident_in[slot_ff]  = next_ident_ff;
                  entry_base_in[slot_ff]   = cur_hb;
                  entry_length_in[slot_ff] = LW'(req_bytes_ff);
                  entry_refs_in[slot_ff]   = RF_W'(1);
                  rsp_status_in = ffra_pkg::ST_OK;
                  rsp_id_in     = next_ident_ff;
                  rsp_refs_in   = RF_W'(1);
                  rsp_addr_in   = AD_W'(cur_hb);
                  rsp_bytes_in  = req_bytes_ff;
                  next_ident_in = (next_ident_ff == '1) ? ID_W'(1) : next_ident_ff + ID_W'(1);
                  state_in      = S_DONE;
               end else begin
                  hole_ix_in = hole_ix_ff + HC_W'(1);
               end
            end else if (!second_ff) begin
               moved_in   = '0;
               cursor_in  = '0;
               tbl_ix_in  = '0;
               pick_ok_in = 1'b0;
               state_in   = S_CMP;
            end else begin
               rsp_status_in = ffra_pkg::ST_NO_SPACE;
               state_in      = S_DONE;
            end
         end

         S_LOOKUP: begin
            // lowest slot holding the id
            if (!tbl_live) begin
               rsp_status_in = ffra_pkg::ST_NOT_FOUND;
               state_in      = S_DONE;
            end else if (id_match) begin
               rsp_id_in    = id_ff;
               rsp_addr_in  = AD_W'(entry_base_ff[t]);
               rsp_bytes_in = BY_W'(entry_length_ff[t]);
               if (mode_ff == ffra_pkg::MODE_RETAIN) begin
                  new_refs = (entry_refs_ff[t] == '1) ? entry_refs_ff[t]
                                                      : entry_refs_ff[t] + RF_W'(1);
               end else begin
                  new_refs = (entry_refs_ff[t] != '0) ? entry_refs_ff[t] - RF_W'(1) : '0;
               end
               entry_refs_in[t] = new_refs;
               rsp_refs_in      = new_refs;
               if (new_refs == '0) begin
                  entry_valid_in[t] = 1'b0;
                  fb_in      = entry_base_ff[t];
                  fl_in      = entry_length_ff[t];
                  hole_ix_in = '0;
                  prev_ok_in = 1'b0;
                  state_in   = S_FREE_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               tbl_ix_in = tbl_ix_ff + TC_W'(1);
            end
         end

         S_FREE_SCAN: begin
            // find the first region at or above the freed base
            if (hole_live && (cur_hb < fb_ff)) begin
               prev_end_in = LW'(cur_hb) + cur_hl;
               prev_len_in = cur_hl;
               prev_ok_in  = 1'b1;
               hole_ix_in  = hole_ix_ff + HC_W'(1);
            end else begin
               state_in = S_FREE_MERGE;
            end
         end

         S_FREE_MERGE: begin
            state_in = S_DONE;
            if (merge_left && merge_right) begin
               for (int j = 0; j < FE - 1; j++) begin
                  if (j >= int'(hk)) begin
                     hole_base_in[j]   = hole_base_ff[j+1];
                     hole_length_in[j] = hole_length_ff[j+1];
                  end
               end
               hole_length_in[hk_left] = prev_len_ff + fl_ff + cur_hl;
               hole_count_in = hole_count_ff - HC_W'(1);
            end else if (merge_left) begin
               hole_length_in[hk_left] = prev_len_ff + fl_ff;
            end else if (merge_right) begin
               hole_base_in[hk]   = fb_ff;
               hole_length_in[hk] = cur_hl + fl_ff;
            end else if (hole_count_ff < HC_W'(FE)) begin
               for (int j = 1; j < FE; j++) begin
                  if (j > int'(hk)) begin
                     hole_base_in[j]   = hole_base_ff[j-1];
                     hole_length_in[j] = hole_length_ff[j-1];
                  end
               end
               hole_base_in[hk]   = fb_ff;
               hole_length_in[hk] = fl_ff;
               hole_count_in      = hole_count_ff + HC_W'(1);
            end else begin
               // free list full: gather all space into one tail
               moved_in   = '0;
               cursor_in  = '0;
               tbl_ix_in  = '0;
               pick_ok_in = 1'b0;
               state_in   = S_CMP;
            end
         end

         S_CMP: begin
            if (tbl_live) begin
               // lowest-based live block not yet moved
               if (entry_valid_ff[t] && !moved_ff[t] &&
                   (!pick_ok_ff || (entry_base_ff[t] < pick_base_ff))) begin
                  pick_in      = t;
                  pick_base_in = entry_base_ff[t];
                  pick_len_in  = entry_length_ff[t];
                  pick_ok_in   = 1'b1;
               end
               tbl_ix_in = tbl_ix_ff + TC_W'(1);
            end else if (pick_ok_ff) begin
               // slide it down to the cursor
               entry_base_in[pick_ff] = AB'(cursor_ff);
               cursor_in       = cursor_ff + pick_len_ff;
               moved_in[pick_ff] = 1'b1;
               pick_ok_in      = 1'b0;
               tbl_ix_in       = '0;
            end else begin
               // single free tail
               hole_count_in = '0;
               if (cursor_ff < pool_ff) begin
                  hole_base_in[0]   = AB'(cursor_ff);
                  hole_length_in[0] = pool_ff - cursor_ff;
                  hole_count_in     = HC_W'(1);
               end
               case (mode_ff)
                  ffra_pkg::MODE_ALLOC: begin
                     hole_ix_in = '0;
                     second_in  = 1'b1;
                     state_in   = S_FIT;
                  end
                  ffra_pkg::MODE_COMPACT: begin
                     if (cursor_ff < pool_ff) begin
                        rsp_addr_in  = AD_W'(cursor_ff);
                        rsp_bytes_in = BY_W'(pool_ff - cursor_ff);
                     end
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_DONE: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         pool_ff           <= ffra_pkg::POOL_RESET;
         entry_valid_ff    <= '0;
         hole_base_ff[0]   <= '0;
         hole_length_ff[0] <= ffra_pkg::POOL_RESET;
         hole_count_ff     <= HC_W'(1);
         next_ident_ff     <= ID_W'(1);
      end else begin
         state_ff       <= state_in;
         pool_ff        <= pool_in;
         entry_valid_ff <= entry_valid_in;
         hole_base_ff   <= hole_base_in;
         hole_length_ff <= hole_length_in;
         hole_count_ff  <= hole_count_in;
         next_ident_ff  <= next_ident_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      req_bytes_ff    <= req_bytes_in;
      id_ff           <= id_in;
      slot_ff         <= slot_in;
      tbl_ix_ff       <= tbl_ix_in;
      hole_ix_ff      <= hole_ix_in;
      second_ff       <= second_in;
      moved_ff        <= moved_in;
      pick_ff         <= pick_in;
      pick_ok_ff      <= pick_ok_in;
      pick_base_ff    <= pick_base_in;
      pick_len_ff     <= pick_len_in;
      cursor_ff       <= cursor_in;
      fb_ff           <= fb_in;
      fl_ff           <= fl_in;
      prev_ok_ff      <= prev_ok_in;
      prev_end_ff     <= prev_end_in;
      prev_len_ff     <= prev_len_in;
      entry_ident_ff  <= entry_ident_in;
      entry_base_ff   <= entry_base_in;
      entry_length_ff <= entry_length_in;
      entry_refs_ff   <= entry_refs_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_refs_ff     <= rsp_refs_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_bytes_ff    <= rsp_bytes_in;
   end

   // checks
   assert property (@(posedge clock) disable iff (reset)
      hole_count_ff <= HC_W'(FE))
      else $error("free list count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      next_ident_ff != '0)
      else $error("next id reached zero");

   assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> (state_ff == S_IDLE))
      else $error("sequencer not idle after result transfer");

endmodule

`default_nettype wire
